@@ rtl/ihcp_pkg.sv @@
// Shared types, constants and helper functions for the IPv6 header chain parser.
package ihcp_pkg;

  localparam logic [15:0] FIXED_LEN    = 16'd40;
  localparam logic [15:0] FIXED_LAST   = 16'd39;
  localparam logic [15:0] POS_MAX      = 16'hFFFF;
  localparam logic [3:0]  IP_VERSION   = 4'd6;

  localparam logic [7:0] NH_HOP_BY_HOP = 8'd0;
  localparam logic [7:0] NH_ROUTING    = 8'd43;
  localparam logic [7:0] NH_FRAGMENT   = 8'd44;
  localparam logic [7:0] NH_DEST_OPTS  = 8'd60;

  typedef enum logic [1:0] {
    PHASE_FIXED,
    PHASE_EXT,
    PHASE_DONE
  } phase_t;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_SHORT,
    STATUS_VERSION,
    STATUS_TRUNC
  } status_t;

  typedef struct packed {
    status_t          status;
    logic [7:0]       tclass;
    logic [19:0]      flow_id;
    logic [15:0]      pay_len;
    logic [7:0]       hop_count;
    logic [7:0]       upper_protocol;
    logic [15:0]      payload_offset;
    logic [3:0][63:0] address;
  } result_t;

  function automatic logic is_option_header(input logic [7:0] t);
    return (t == NH_HOP_BY_HOP) || (t == NH_ROUTING) || (t == NH_DEST_OPTS);
  endfunction

  function automatic logic is_skipped_header(input logic [7:0] t);
    return is_option_header(t) || (t == NH_FRAGMENT);
  endfunction

endpackage

@@ rtl/ihcp_walker.sv @@
// Input register, header capture and extension chain walk for one byte per cycle while the output buffer has space.
module ihcp_walker (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,
  input  logic              s_tlast,
  input  logic              space,
  output logic              push,
  output ihcp_pkg::result_t res
);

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        advance;

  logic [15:0]          byte_position, byte_position_next;
  ihcp_pkg::phase_t     phase, phase_next, phase_upd;
  logic [7:0]           current_next, current_next_next, current_next_upd;
  logic [15:0]          extension_end, extension_end_next, extension_end_upd;
  logic [15:0]          header_offset, header_offset_next, header_offset_upd;
  logic [7:0]           pending_next, pending_next_next, pending_next_upd;
  logic [31:0]          first_word, first_word_next;
  logic [23:0]          length_and_hops, length_and_hops_next;
  logic [3:0][63:0]     address_store, address_store_next;

  logic [1:0]  addr_index;
  logic [16:0] offset_plus1;
  logic [16:0] end_fixed;
  logic [17:0] end_option;
  ihcp_pkg::status_t status;

  assign advance  = in_valid && space;
  assign s_tready = !in_valid || space;
  assign push     = advance && in_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  assign addr_index   = byte_position[4:3] - 2'd1;
  assign offset_plus1 = {1'b0, header_offset} + 17'd1;
  assign end_fixed    = {1'b0, header_offset} + 17'd7;
  assign end_option   = {2'b00, header_offset} + {7'd0, in_byte, 3'b111};

  always_comb begin
    phase_upd            = phase;
    current_next_upd     = current_next;
    extension_end_upd    = extension_end;
    header_offset_upd    = header_offset;
    pending_next_upd     = pending_next;
    first_word_next      = first_word;
    length_and_hops_next = length_and_hops;
    address_store_next   = address_store;
    unique case (phase)
      ihcp_pkg::PHASE_FIXED: begin
        if (byte_position < 16'd4) begin
          first_word_next = {first_word[23:0], in_byte};
        end else if (byte_position == 16'd4 || byte_position == 16'd5 ||
                     byte_position == 16'd7) begin
          length_and_hops_next = {length_and_hops[15:0], in_byte};
        end else if (byte_position == 16'd6) begin
          current_next_upd = in_byte;
        end else if (byte_position < ihcp_pkg::FIXED_LEN) begin
          address_store_next[addr_index] = {address_store[addr_index][55:0], in_byte};
        end
        if (byte_position == ihcp_pkg::FIXED_LAST) begin
          header_offset_upd = ihcp_pkg::FIXED_LEN;
          phase_upd = ihcp_pkg::is_skipped_header(current_next) ?
                      ihcp_pkg::PHASE_EXT : ihcp_pkg::PHASE_DONE;
        end
      end
      ihcp_pkg::PHASE_EXT: begin
        if (byte_position != ihcp_pkg::POS_MAX) begin
          if (byte_position == header_offset) begin
            pending_next_upd  = in_byte;
            extension_end_upd = end_fixed[16] ? ihcp_pkg::POS_MAX : end_fixed[15:0];
          end else if ({1'b0, byte_position} == offset_plus1 &&
                       ihcp_pkg::is_option_header(current_next)) begin
            extension_end_upd = (end_option[17:16] != 2'b00) ? ihcp_pkg::POS_MAX :
                                end_option[15:0];
          end
          if (byte_position == extension_end_upd) begin
            current_next_upd  = pending_next_upd;
            header_offset_upd = byte_position + 16'd1;
            if (!ihcp_pkg::is_skipped_header(pending_next_upd)) begin
              phase_upd = ihcp_pkg::PHASE_DONE;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (in_last) begin
      byte_position_next = 16'd0;
      phase_next         = ihcp_pkg::PHASE_FIXED;
      current_next_next  = 8'd0;
      extension_end_next = 16'd0;
      header_offset_next = 16'd0;
      pending_next_next  = 8'd0;
    end else begin
      byte_position_next = (byte_position == ihcp_pkg::POS_MAX) ? byte_position :
                           byte_position + 16'd1;
      phase_next         = phase_upd;
      current_next_next  = current_next_upd;
      extension_end_next = extension_end_upd;
      header_offset_next = header_offset_upd;
      pending_next_next  = pending_next_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 16'd0;
      phase         <= ihcp_pkg::PHASE_FIXED;
      current_next  <= 8'd0;
      extension_end <= 16'd0;
      header_offset <= 16'd0;
      pending_next  <= 8'd0;
    end else if (advance) begin
      byte_position <= byte_position_next;
      phase         <= phase_next;
      current_next  <= current_next_next;
      extension_end <= extension_end_next;
      header_offset <= header_offset_next;
      pending_next  <= pending_next_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      first_word      <= first_word_next;
      length_and_hops <= length_and_hops_next;
      address_store   <= address_store_next;
    end
  end

  always_comb begin
    if (first_word_next[31:28] != ihcp_pkg::IP_VERSION) begin
      status = ihcp_pkg::STATUS_VERSION;
    end else if (phase_upd == ihcp_pkg::PHASE_EXT) begin
      status = ihcp_pkg::STATUS_TRUNC;
    end else begin
      status = ihcp_pkg::STATUS_OK;
    end
  end

  always_comb begin
    if (byte_position < ihcp_pkg::FIXED_LAST) begin
      res        = '0;
      res.status = ihcp_pkg::STATUS_SHORT;
    end else begin
      res.status         = status;
      res.tclass         = first_word_next[27:20];
      res.flow_id        = first_word_next[19:0];
      res.pay_len        = length_and_hops_next[23:8];
      res.hop_count      = length_and_hops_next[7:0];
      res.upper_protocol = (status == ihcp_pkg::STATUS_OK) ? current_next_upd : 8'd0;
      res.payload_offset = (status == ihcp_pkg::STATUS_OK) ? header_offset_upd : 16'd0;
      res.address        = address_store_next;
    end
  end

endmodule

@@ rtl/ihcp_out_buf.sv @@
// Result register with a skid entry so the walker keeps taking bytes during a stall until the skid entry is full.
module ihcp_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ihcp_pkg::result_t res,
  output logic              space,
  output logic              m_tvalid,
  input  logic              m_tready,
  output ihcp_pkg::result_t m_res
);

  logic              skid_valid;
  ihcp_pkg::result_t skid;
  logic              main_free;
  logic              take_skid;
  logic              take_push;
  logic              skid_load;

  assign space     = !skid_valid;
  assign main_free = !m_tvalid || m_tready;
  assign take_skid = main_free && skid_valid;
  assign take_push = main_free && !skid_valid && push;
  assign skid_load = !main_free && push;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (main_free) begin
        m_tvalid <= skid_valid || push;
      end
      if (take_skid) begin
        skid_valid <= 1'b0;
      end else if (skid_load) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_skid) begin
      m_res <= skid;
    end else if (take_push) begin
      m_res <= res;
    end
    if (skid_load) begin
      skid <= res;
    end
  end

endmodule

@@ rtl/ipv6_header_chain_parser.sv @@
// Top level of the IPv6 fixed header and extension header chain parser.
//
//   Channel  Direction  Contents
//   s_*      in         one packet byte per transfer, tlast on the final byte
//   m_*      out        one parse result per packet, status in tuser
//
// One byte is taken per cycle while the skid entry is free; the walk holds no loop across cycles.
// A result is registered in the output buffer once the final byte leaves the input register;
// a full skid entry can hold the final byte back.
// A stalled result sits in the output register and a skid entry keeps input flowing
// until both are full.
// Reset clears the parse position and phase; a packet then starts at byte zero.
module ipv6_header_chain_parser (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,  // packet_byte
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [335:0] m_tdata,  // tclass, flow_id, pay_len, hop_count,
                                 // upper_protocol, payload_offset, source_high, source_low,
                                 // destination_high, destination_low, zero fill
  output logic [1:0]   m_tuser   // status
);

  logic              space;
  logic              push;
  ihcp_pkg::result_t res;
  ihcp_pkg::result_t m_res;

  ihcp_walker u_walker (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .space    (space),
    .push     (push),
    .res      (res)
  );

  ihcp_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .res      (res),
    .space    (space),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_res    (m_res)
  );

  assign m_tuser = m_res.status;
  assign m_tdata = {4'd0, m_res.address[3], m_res.address[2], m_res.address[1],
                    m_res.address[0], m_res.payload_offset, m_res.upper_protocol,
                    m_res.hop_count, m_res.pay_len, m_res.flow_id,
                    m_res.tclass};

endmodule

@@ tb/sv/ipv6_header_chain_parser_tb.sv @@
// Self-checking testbench for the IPv6 header chain parser, driven by directed and random packets.
module ipv6_header_chain_parser_tb;
  import ihcp_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam logic [7:0] WALKED_NH [4] = '{NH_HOP_BY_HOP, NH_ROUTING, NH_FRAGMENT, NH_DEST_OPTS};

  typedef enum {
    SH_FILL,
    SH_NOISE,
    SH_CHAIN,
    SH_CUT
  } shape_t;

  typedef struct {
    shape_t     shape;
    int         len;
    logic [3:0] ver;
    int         n_ext;
    int         pick;
    int         opt_len;
    logic [7:0] fill;
    bit         typed;
    status_t    want;
  } frame_spec_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = 8'h00;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b1;
  logic [335:0] m_tdata;
  logic [1:0]   m_tuser;

  logic [7:0] frame_bytes [$];
  result_t    results_due [$];
  int         mismatch_count = 0;
  int         cycle_count = 0;
  bit         calm = 1'b0;

  logic [15:0] pos_r;
  phase_t      phase_r;
  logic [7:0]  cur_nh;
  logic [7:0]  held_nh;
  logic [15:0] ext_last;
  logic [15:0] hdr_start;
  logic [31:0] ver_word;
  logic [23:0] len_hop;
  logic [63:0] addr_r [4];

  // Columns: shape, len, version, extensions, type, option length, fill, typed, status.
  frame_spec_t directed_frames [18] = '{
    '{SH_FILL,  1,     4'd0,       0,  -1,                 -1,  8'h00, 1'b1, STATUS_SHORT},
    '{SH_FILL,  39,    4'd0,       0,  -1,                 -1,  8'hFF, 1'b1, STATUS_SHORT},
    '{SH_FILL,  40,    4'd0,       0,  -1,                 -1,  8'hFF, 1'b1, STATUS_VERSION},
    '{SH_FILL,  40,    4'd0,       0,  -1,                 -1,  8'h00, 1'b1, STATUS_VERSION},
    '{SH_FILL,  40,    4'd0,       0,  -1,                 -1,  8'h60, 1'b1, STATUS_OK},
    '{SH_NOISE, 2,     4'd0,       0,  -1,                 -1,  8'h00, 1'b1, STATUS_SHORT},
    '{SH_CHAIN, 0,     IP_VERSION, 0,  -1,                 -1,  8'h00, 1'b0, STATUS_OK},
    '{SH_CHAIN, 4,     IP_VERSION, 1,  int'(NH_HOP_BY_HOP), 0,  8'h00, 1'b0, STATUS_OK},
    '{SH_CUT,   12,    IP_VERSION, 1,  int'(NH_ROUTING),   255, 8'h00, 1'b1, STATUS_TRUNC},
    '{SH_CHAIN, 3,     IP_VERSION, 1,  int'(NH_FRAGMENT),  -1,  8'h00, 1'b0, STATUS_OK},
    '{SH_CHAIN, 0,     IP_VERSION, 1,  int'(NH_DEST_OPTS), 1,   8'h00, 1'b0, STATUS_OK},
    '{SH_CHAIN, 10,    IP_VERSION, 4,  -1,                 0,   8'h00, 1'b0, STATUS_OK},
    '{SH_CUT,   0,     IP_VERSION, 1,  -1,                 -1,  8'h00, 1'b1, STATUS_TRUNC},
    '{SH_CUT,   5,     IP_VERSION, 2,  -1,                 -1,  8'h00, 1'b1, STATUS_TRUNC},
    '{SH_CHAIN, 8,     4'd4,       2,  -1,                 -1,  8'h00, 1'b1, STATUS_VERSION},
    '{SH_CUT,   3,     4'd7,       1,  -1,                 -1,  8'h00, 1'b1, STATUS_VERSION},
    '{SH_CUT,   8,     IP_VERSION, 1,  int'(NH_FRAGMENT),  -1,  8'h00, 1'b1, STATUS_OK},
    '{SH_CUT,   7,     IP_VERSION, 1,  int'(NH_FRAGMENT),  -1,  8'h00, 1'b1, STATUS_TRUNC}
  };

  ipv6_header_chain_parser u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #4 clk = ~clk;

  function automatic bit has_len_byte(input logic [7:0] t);
    return t == NH_HOP_BY_HOP || t == NH_ROUTING || t == NH_DEST_OPTS;
  endfunction

  function automatic bit is_walked(input logic [7:0] t);
    return has_len_byte(t) || t == NH_FRAGMENT;
  endfunction

  function automatic logic [15:0] sat16(input int v);
    return v > int'(POS_MAX) ? POS_MAX : v[15:0];
  endfunction

  task automatic parser_clear();
    pos_r = '0;
    phase_r = PHASE_FIXED;
    cur_nh = '0;
    held_nh = '0;
    ext_last = '0;
    hdr_start = '0;
    ver_word = '0;
    len_hop = '0;
    foreach (addr_r[k]) addr_r[k] = '0;
  endtask

  task automatic parse_step(input logic [7:0] b, input logic last, output bit done,
                            output result_t r);
    int p;
    int k;
    p = int'(pos_r);
    done = 1'b0;
    r = '0;
    if (phase_r == PHASE_FIXED) begin
      if (p < 4) begin
        ver_word = {ver_word[23:0], b};
      end else if (p == 4 || p == 5 || p == 7) begin
        len_hop = {len_hop[15:0], b};
      end else if (p == 6) begin
        cur_nh = b;
      end else if (p < int'(FIXED_LEN)) begin
        k = ((p - 8) >> 3) & 3;
        addr_r[k] = {addr_r[k][55:0], b};
      end
      if (p == int'(FIXED_LAST)) begin
        hdr_start = FIXED_LEN;
        phase_r = is_walked(cur_nh) ? PHASE_EXT : PHASE_DONE;
      end
    end else if (phase_r == PHASE_EXT && p < int'(POS_MAX)) begin
      if (p == int'(hdr_start)) begin
        held_nh = b;
        ext_last = sat16(int'(hdr_start) + 7);
      end else if (p == int'(hdr_start) + 1 && has_len_byte(cur_nh)) begin
        ext_last = sat16(int'(hdr_start) + (int'(b) + 1) * 8 - 1);
      end
      if (p == int'(ext_last)) begin
        cur_nh = held_nh;
        hdr_start = 16'(p + 1);
        if (!is_walked(cur_nh)) phase_r = PHASE_DONE;
      end
    end
    if (pos_r != POS_MAX) pos_r = pos_r + 16'd1;
    if (last) begin
      done = 1'b1;
      if (p < int'(FIXED_LAST)) begin
        r.status = STATUS_SHORT;
      end else begin
        if (ver_word[31:28] != IP_VERSION) r.status = STATUS_VERSION;
        else if (phase_r == PHASE_EXT) r.status = STATUS_TRUNC;
        else r.status = STATUS_OK;
        r.tclass = ver_word[27:20];
        r.flow_id = ver_word[19:0];
        r.pay_len = len_hop[23:8];
        r.hop_count = len_hop[7:0];
        if (r.status == STATUS_OK) begin
          r.upper_protocol = cur_nh;
          r.payload_offset = hdr_start;
        end
        for (int j = 0; j < 4; j++) r.address[j] = addr_r[j];
      end
      parser_clear();
    end
  endtask

  task automatic build_frame(input frame_spec_t c);
    logic [7:0] chain_nh [$];
    logic [7:0] upper;
    int olen;
    int span;
    int cut;
    frame_bytes.delete();
    case (c.shape)
      SH_FILL: begin
        repeat (c.len) frame_bytes.push_back(c.fill);
      end
      SH_NOISE: begin
        repeat (c.len) frame_bytes.push_back(8'($urandom));
      end
      default: begin
        do upper = 8'($urandom_range(0, 255)); while (is_walked(upper));
        for (int i = 0; i < c.n_ext; i++) begin
          chain_nh.push_back(c.pick >= 0 ? 8'(c.pick) : WALKED_NH[2'($urandom_range(0, 3))]);
        end
        chain_nh.push_back(upper);
        frame_bytes.push_back({c.ver, 4'($urandom)});
        repeat (5) frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(chain_nh[0]);
        repeat (33) frame_bytes.push_back(8'($urandom));
        for (int i = 0; i < c.n_ext; i++) begin
          frame_bytes.push_back(chain_nh[i + 1]);
          if (has_len_byte(chain_nh[i])) begin
            if (c.opt_len >= 0) olen = c.opt_len;
            else if ($urandom_range(0, 39) == 0) olen = $urandom_range(0, 31);
            else olen = $urandom_range(0, 3);
            frame_bytes.push_back(8'(olen));
            span = (olen + 1) * 8;
          end else begin
            frame_bytes.push_back(8'($urandom));
            span = 8;
          end
          repeat (span - 2) frame_bytes.push_back(8'($urandom));
        end
        if (c.shape == SH_CUT) begin
          if (c.len >= 0) cut = int'(FIXED_LEN) + c.len;
          else cut = $urandom_range(int'(FIXED_LEN), frame_bytes.size() - 1);
          while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
        end else begin
          repeat (c.len) frame_bytes.push_back(8'($urandom));
        end
      end
    endcase
  endtask

  task automatic send_frame(input frame_spec_t c);
    bit done;
    bit last;
    result_t r;
    build_frame(c);
    foreach (frame_bytes[i]) begin
      if (!calm && $urandom_range(0, 11) == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      last = (i == frame_bytes.size() - 1);
      s_tvalid <= 1'b1;
      s_tdata <= frame_bytes[i];
      s_tlast <= last;
      @(posedge clk);
      while (!s_tready) @(posedge clk);
      parse_step(frame_bytes[i], last, done, r);
      if (done) begin
        if (c.typed) begin
          if (c.want == STATUS_SHORT) begin
            r = '0;
          end else if (c.want != STATUS_OK) begin
            r.upper_protocol = '0;
            r.payload_offset = '0;
          end
          r.status = c.want;
        end
        results_due.push_back(r);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (results_due.size() == 0) begin
        $display("%0t: result expected none, got status %0h", $time, m_tuser);
        mismatch_count++;
      end else begin
        want = results_due.pop_front();
        check_field("status", 64'(want.status), 64'(m_tuser));
        check_field("tclass", 64'(want.tclass), 64'(m_tdata[7:0]));
        check_field("flow_id", 64'(want.flow_id), 64'(m_tdata[27:8]));
        check_field("pay_len", 64'(want.pay_len), 64'(m_tdata[43:28]));
        check_field("hop_count", 64'(want.hop_count), 64'(m_tdata[51:44]));
        check_field("upper_protocol", 64'(want.upper_protocol), 64'(m_tdata[59:52]));
        check_field("payload_offset", 64'(want.payload_offset), 64'(m_tdata[75:60]));
        check_field("source_high", want.address[0], m_tdata[139:76]);
        check_field("source_low", want.address[1], m_tdata[203:140]);
        check_field("destination_high", want.address[2], m_tdata[267:204]);
        check_field("destination_low", want.address[3], m_tdata[331:268]);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    forever begin
      if (!calm && $urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    frame_spec_t f;
    int sent;
    int roll;
    int v;
    parser_clear();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    sent = 0;
    foreach (directed_frames[i]) begin
      send_frame(directed_frames[i]);
      sent += frame_bytes.size();
    end

    while (sent < 1800) begin
      roll = $urandom_range(0, 99);
      f.shape = SH_CHAIN;
      f.len = $urandom_range(0, 16);
      f.ver = IP_VERSION;
      f.n_ext = $urandom_range(0, 4);
      f.pick = -1;
      f.opt_len = -1;
      f.fill = 8'h00;
      f.typed = 1'b0;
      f.want = STATUS_OK;
      if (roll >= 92) begin
        f.shape = SH_NOISE;
        f.len = $urandom_range(1, 100);
      end else if (roll >= 85) begin
        v = $urandom_range(0, 14);
        if (v >= int'(IP_VERSION)) v++;
        f.ver = 4'(v);
      end else if (roll >= 77) begin
        f.shape = SH_NOISE;
        f.len = $urandom_range(1, 39);
      end else if (roll >= 65) begin
        f.shape = SH_CUT;
        f.n_ext = $urandom_range(1, 4);
        f.len = -1;
      end
      calm = (sent >= 1550);
      send_frame(f);
      sent += frame_bytes.size();
    end
    s_tvalid <= 1'b0;
    s_tlast <= 1'b0;

    while (results_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
